>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks, compiled away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/srem_pkg.sv
// ----------------------------------------------------------------------------
// srem_pkg
// shared widths and the per-stage record of the remainder pipeline
// ----------------------------------------------------------------------------
package srem_pkg;

  localparam int DATA_W    = 64;
  localparam int NUM_STEPS = DATA_W;

  typedef logic [DATA_W-1:0] word_t;

  // one item in flight through the shift-subtract stages
  typedef struct packed {
    logic  neg;       // numerator was negative
    logic  den_zero;  // divisor is zero, result forced to zero
    word_t rem;       // partial remainder
    word_t dvd;       // dividend bits not yet shifted in (msb first)
    word_t dsr;       // divisor magnitude
  } stage_t;

endpackage

>>> sv/srem_in_if.sv
// ----------------------------------------------------------------------------
// srem_in_if
// request channel: numerator and denominator with valid/ready
// ----------------------------------------------------------------------------
interface srem_in_if;
  import srem_pkg::*;

  logic              valid;
  logic              ready;
  logic signed [DATA_W-1:0] numerator;
  logic signed [DATA_W-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

>>> sv/srem_out_if.sv
// ----------------------------------------------------------------------------
// srem_out_if
// response channel: signed remainder with valid/ready
// ----------------------------------------------------------------------------
interface srem_out_if;
  import srem_pkg::*;

  logic              valid;
  logic              ready;
  logic signed [DATA_W-1:0] modulo_result;

  modport source (output valid, output modulo_result, input ready);
  modport sink   (input valid, input modulo_result, output ready);
endinterface

>>> sv/signed_64bit_remainder.sv
// ----------------------------------------------------------------------------
// signed_64bit_remainder
// pipelined signed 64-bit remainder, truncating rule (sign of numerator)
//
// req_i carries numerator and denominator, rsp_o carries modulo_result;
// a beat moves on either channel when valid and ready are both high.
// a zero denominator gives 0; -2^63 is taken as magnitude 2^63.
// pipeline from request beat to response valid: one operand stage,
// 64 shift-subtract stages, one sign fix-up stage.
// throughput: one beat per cycle; each shift-subtract stage holds one 64-bit subtract.
// when rsp_o stalls, the pending result drops into a skid slot as the
// pipe advances; while the slot is full the whole pipe holds and
// req_i.ready is low. req_i.ready comes from a register.
// reset clears all valid bits and the skid slot; data regs are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_64bit_remainder (
  input  logic       clk_i,
  input  logic       rst_ni,
  srem_in_if.sink    req_i,
  srem_out_if.source rsp_o
);
  import srem_pkg::*;

  // global advance, low only while the skid slot holds a result
  logic   en;

  // stage records: index 0 is the operand stage, NUM_STEPS the last step
  stage_t st    [NUM_STEPS+1];
  logic   st_vld[NUM_STEPS+1];
  word_t  rsp_data;

  assign req_i.ready = en;

  // operand magnitudes and flags
  srem_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid),
    .num_i   (word_t'(req_i.numerator)),
    .den_i   (word_t'(req_i.denominator)),
    .st_o    (st[0]),
    .valid_o (st_vld[0])
  );

  // one restoring step per stage, msb of the dividend first
  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
    srem_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .st_i    (st[g]),
      .valid_i (st_vld[g]),
      .st_o    (st[g+1]),
      .valid_o (st_vld[g+1])
    );
  end

  // sign fix-up, output register, skid slot
  srem_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .st_i        (st[NUM_STEPS]),
    .valid_i     (st_vld[NUM_STEPS]),
    .en_o        (en),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (rsp_data)
  );

  assign rsp_o.modulo_result = rsp_data;

  // an accepted request shows up in the operand stage next cycle
  `ASSERT_NEXT(a_req_enters, clk_i, rst_ni, req_i.valid && req_i.ready, st_vld[0])

  // after the last step the remainder is below the divisor
  `ASSERT_IMPLIES(a_rem_bound, clk_i, rst_ni, st_vld[NUM_STEPS] && !st[NUM_STEPS].den_zero, st[NUM_STEPS].rem < st[NUM_STEPS].dsr)

  // while the pipe holds, a result is on offer
  `ASSERT_IMPLIES(a_hold_has_rsp, clk_i, rst_ni, !en, rsp_o.valid)

  // a held result stays put until taken
  `ASSERT_NEXT(a_rsp_stable, clk_i, rst_ni, rsp_o.valid && !rsp_o.ready, rsp_o.valid && $stable(rsp_o.modulo_result))

endmodule

>>> sv/srem_prep.sv
// ----------------------------------------------------------------------------
// srem_prep
// input stage: operand magnitudes, sign and zero-divisor flags
// ----------------------------------------------------------------------------
module srem_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  srem_pkg::word_t      num_i,
  input  srem_pkg::word_t      den_i,
  output srem_pkg::stage_t     st_o,
  output logic                 valid_o
);
  import srem_pkg::*;

  stage_t st_d, st_q;
  logic   valid_q;

  always_comb begin
    st_d.neg      = num_i[DATA_W-1];
    st_d.den_zero = (den_i == '0);
    st_d.rem      = '0;
    st_d.dvd      = num_i[DATA_W-1] ? (~num_i) + DATA_W'(1) : num_i;
    st_d.dsr      = den_i[DATA_W-1] ? (~den_i) + DATA_W'(1) : den_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign st_o    = st_q;
  assign valid_o = valid_q;
endmodule

>>> sv/srem_step.sv
// ----------------------------------------------------------------------------
// srem_step
// one restoring shift-subtract step, registered
// ----------------------------------------------------------------------------
module srem_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  srem_pkg::stage_t     st_i,
  input  logic                 valid_i,
  output srem_pkg::stage_t     st_o,
  output logic                 valid_o
);
  import srem_pkg::*;

  stage_t            st_d, st_q;
  logic              valid_q;
  word_t             shifted;
  logic [DATA_W:0]   diff;

  always_comb begin
    // with a nonzero divisor, rem < divisor <= 2^63, so the top bit shifted out is zero
    shifted       = {st_i.rem[DATA_W-2:0], st_i.dvd[DATA_W-1]};
    diff          = {1'b0, shifted} - {1'b0, st_i.dsr};
    st_d          = st_i;
    st_d.rem      = diff[DATA_W] ? shifted : diff[DATA_W-1:0];
    st_d.dvd      = {st_i.dvd[DATA_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign st_o    = st_q;
  assign valid_o = valid_q;
endmodule

>>> sv/srem_out.sv
// ----------------------------------------------------------------------------
// srem_out
// sign fix-up, output register and skid buffer
// ----------------------------------------------------------------------------
module srem_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srem_pkg::stage_t     st_i,
  input  logic                 valid_i,
  output logic                 en_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output srem_pkg::word_t      out_data_o
);
  import srem_pkg::*;

  word_t res_d, res_q;
  logic  res_valid_q;
  word_t skid_q;
  logic  skid_valid_q;

  // the whole pipe moves whenever the skid slot is free
  assign en_o = !skid_valid_q;

  always_comb begin
    if (st_i.den_zero) begin
      res_d = '0;
    end else if (st_i.neg) begin
      res_d = (~st_i.rem) + DATA_W'(1);
    end else begin
      res_d = st_i.rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      res_q <= res_d;
    end
    if (en_o && res_valid_q && !out_ready_i) begin
      skid_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (en_o) begin
        res_valid_q <= valid_i;
      end
      if (skid_valid_q) begin
        if (out_ready_i) begin
          skid_valid_q <= 1'b0;
        end
      end else if (res_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // the skid entry is always older than the output register
  assign out_valid_o = skid_valid_q || res_valid_q;
  assign out_data_o  = skid_valid_q ? skid_q : res_q;
endmodule

>>> sim/signed_64bit_remainder_tb.sv
// ----------------------------------------------------------------------------
// signed_64bit_remainder_tb
// self-checking bench for the pipelined signed 64-bit remainder
//
// a driver pulls operand pairs from a pending queue and offers them on
// req_i; a monitor computes the truncating remainder of every request beat
// and checks each response beat against the oldest outstanding value.
// directed corner operands come first, then random operands in several
// flow-control phases, one of them a long response hold-off that backs the
// pipe up into the request channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_64bit_remainder_tb;
  import srem_pkg::*;

  localparam word_t WORD_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
  localparam word_t WORD_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_ONES  = {DATA_W{1'b1}};
  localparam int    QUIET_MAX  = 5000;  // cycles without any beat before giving up
  localparam int    HOLD_LEN   = 300;   // long response hold-off, in cycles
  localparam int    DRAIN_WAIT = 80;    // watch after the drain, longer than the pipeline latency

  typedef struct packed {
    word_t numerator;
    word_t denominator;
  } operand_pair_t;

  logic clk_i;
  logic rst_ni;

  srem_in_if  req_bus ();
  srem_out_if rsp_bus ();

  signed_64bit_remainder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // operand pairs waiting to be offered, and remainders waiting to come back
  operand_pair_t pending_pairs[$];
  word_t         expected_rems[$];

  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned hold_requests = 0;  // bumped by stimulus to ask for a long hold-off
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned error_count   = 0;

  // truncating remainder: restoring division on magnitudes, sign of numerator
  function automatic word_t truncating_remainder(word_t num, word_t den);
    word_t       num_mag;
    word_t       den_mag;
    word_t       part;
    logic [64:0] trial;
    num_mag = num[DATA_W-1] ? ~num + 1'b1 : num;
    den_mag = den[DATA_W-1] ? ~den + 1'b1 : den;
    if (den_mag == '0) begin
      return '0;
    end
    part = '0;
    for (int step = 0; step < DATA_W; step++) begin
      // partial remainder stays below the divisor, so one extra bit suffices
      trial   = {part, num_mag[DATA_W-1]};
      num_mag = num_mag << 1;
      if (trial >= {1'b0, den_mag}) begin
        trial = trial - {1'b0, den_mag};
      end
      part = trial[DATA_W-1:0];
    end
    // negating zero gives zero, so no negative zero can appear
    return num[DATA_W-1] ? ~part + 1'b1 : part;
  endfunction

  // operand with a mix of shapes: corners, short magnitudes, full width
  function automatic word_t random_operand();
    word_t w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: w = WORD_MIN;
      1: w = WORD_MAX;
      2: w = '0;
      3: w = WORD_ONES;
      4: begin
        w = word_t'($urandom_range(1, 20));
        if ($urandom_range(0, 1)) w = ~w + 1'b1;
      end
      5, 6, 7, 8, 9: begin
        w = w >> $urandom_range(1, DATA_W - 1);
        if ($urandom_range(0, 1)) w = ~w + 1'b1;
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic operand_pair_t random_pair();
    operand_pair_t p;
    p.numerator = random_operand();
    if ($urandom_range(0, 9) < 3) begin
      // divisor close to the numerator scale so the quotient is short
      p.denominator = p.numerator >> $urandom_range(0, 8);
      p.denominator = p.denominator + word_t'($urandom_range(0, 6)) - word_t'(3);
      if ($urandom_range(0, 1)) p.denominator = ~p.denominator + 1'b1;
    end else begin
      p.denominator = random_operand();
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    // every input known from time zero
    req_bus.valid       = 1'b0;
    req_bus.numerator   = '0;
    req_bus.denominator = '0;
    rsp_bus.ready       = 1'b0;
    rst_ni              = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // request driver: valid holds with its data until the beat is taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    operand_pair_t pair;
    if (!rst_ni) begin
      req_bus.valid       <= 1'b0;
      req_bus.numerator   <= '0;
      req_bus.denominator <= '0;
    end else if (!req_bus.valid || req_bus.ready) begin
      if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        pair                 = pending_pairs.pop_front();
        req_bus.valid       <= 1'b1;
        req_bus.numerator   <= pair.numerator;
        req_bus.denominator <= pair.denominator;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // response ready: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      hold_left     <= 0;
      holds_served  <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served  <= hold_requests;
      hold_left     <= HOLD_LEN;
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on request beats, check on response beats
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : beat_monitor
    word_t want;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        expected_rems.push_back(truncating_remainder(req_bus.numerator,
                                                     req_bus.denominator));
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_rems.size() == 0) begin
          error_count++;
          $display("%0t: unexpected remainder beat: expected none, actual %h",
                   $time, rsp_bus.modulo_result);
        end else begin
          want = expected_rems.pop_front();
          if (rsp_bus.modulo_result !== want) begin
            error_count++;
            $display("%0t: modulo_result mismatch: expected %h, actual %h",
                     $time, want, rsp_bus.modulo_result);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without a beat on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic add_pair(word_t num, word_t den);
    operand_pair_t p;
    p.numerator   = num;
    p.denominator = den;
    pending_pairs.push_back(p);
  endtask

  // one flow-control phase; knobs change on the falling edge, clear of the
  // clocked processes that read them
  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                           int unsigned count, bit long_hold);
    @(negedge clk_i);
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    for (int unsigned i = 0; i < count; i++) pending_pairs.push_back(random_pair());
    if (long_hold) hold_requests++;
    while (pending_pairs.size() > 0) @(negedge clk_i);
  endtask

  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);

    // directed corners
    add_pair('0, '0);
    add_pair(word_t'(5), '0);                        // zero divisor
    add_pair(~word_t'(5) + 1'b1, '0);
    add_pair(WORD_MIN, '0);
    add_pair(WORD_MIN, WORD_ONES);                   // -2^63 rem -1
    add_pair(WORD_MIN, WORD_MIN);                    // most negative both sides
    add_pair(WORD_MAX, WORD_MIN);                    // divisor magnitude 2^63
    add_pair(~word_t'(7) + 1'b1, WORD_MIN);
    add_pair(WORD_ONES, WORD_MIN);
    add_pair('0, WORD_MIN);
    add_pair(WORD_MIN, word_t'(1));
    add_pair(WORD_MIN, WORD_MAX);
    add_pair(WORD_MIN, word_t'(7));
    add_pair(WORD_MAX, WORD_MAX);
    add_pair(WORD_MAX, WORD_ONES);
    add_pair(WORD_MAX, word_t'(2));
    add_pair(~word_t'(6) + 1'b1, word_t'(3));        // negative numerator, exact
    add_pair(word_t'(7), word_t'(3));
    add_pair(~word_t'(7) + 1'b1, word_t'(3));
    add_pair(word_t'(7), ~word_t'(3) + 1'b1);
    add_pair(~word_t'(7) + 1'b1, ~word_t'(3) + 1'b1);
    add_pair(word_t'(1), WORD_MAX);
    add_pair(WORD_ONES, WORD_ONES);

    run_phase(0, 0, 375, 1'b0);     // back to back both ways
    run_phase(0, 0, 150, 1'b1);     // long hold-off, pipe backs up into req_i
    run_phase(57, 0, 375, 1'b0);    // sender gaps
    run_phase(0, 57, 375, 1'b0);    // receiver stalls
    run_phase(11, 11, 375, 1'b0);   // light gaps on both

    // let everything drain, then watch a little longer for stray beats
    @(negedge clk_i);
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    while (req_bus.valid || expected_rems.size() > 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/srem_pkg.sv
sv/srem_in_if.sv
sv/srem_out_if.sv
sv/srem_prep.sv
sv/srem_step.sv
sv/srem_out.sv
sv/signed_64bit_remainder.sv
sim/signed_64bit_remainder_tb.sv
